// ===== rtl/core/pd_attitude_torque_law_core_defines.svh =====
// ---------------------------------------------------------------------------
// PD attitude torque law: assertion macros
// Shared helper macros for concurrent checks on the core's ports.
// ---------------------------------------------------------------------------
`ifndef PD_ATTITUDE_TORQUE_LAW_CORE_DEFINES_SVH
`define PD_ATTITUDE_TORQUE_LAW_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PDAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pdat_pkg.sv =====
// ---------------------------------------------------------------------------
// PD attitude torque law package
// Fixed-point widths, datapath types, register codes and field helpers.
// ---------------------------------------------------------------------------
package pdat_pkg;

	// Configuration port.
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 48;

	// Pipeline depth (register stages from input to output register).
	localparam int NST = 10;

	// Datapath widths, chosen from the worst-case magnitude at each point.
	localparam int DW  = 34; // attitude error, Q6.28
	localparam int HW  = 20; // attitude error rounded to Q14
	localparam int CW  = 40; // attitude matrix entries, 2^-28
	localparam int PWW = 56; // matrix entry times rate
	localparam int RSW = 57; // sum of three of those
	localparam int WBW = 35; // resolved command rate, 2^-16 rad/s
	localparam int EW  = 36; // rate error, 2^-16 rad/s
	localparam int APW = 50; // proportional product
	localparam int KDW = 53; // derivative product
	localparam int TW  = 64; // full torque sum, 2^-36 Nm
	localparam int TRW = 36; // torque rounded to 2^-8 Nm
	localparam int OW  = 17; // output torque

	typedef logic signed [15:0]    q_t;
	typedef logic signed [31:0]    qprod_t;
	typedef logic signed [DW-1:0]  dq_t;
	typedef logic signed [HW-1:0]  hq_t;
	typedef logic signed [CW-1:0]  cm_t;
	typedef logic signed [PWW-1:0] rprod_t;
	typedef logic signed [RSW-1:0] rsum_t;
	typedef logic signed [WBW-1:0] wcb_t;
	typedef logic signed [EW-1:0]  werr_t;
	typedef logic signed [APW-1:0] apd_t;
	typedef logic signed [KDW-1:0] kdw_t;
	typedef logic signed [TW-1:0]  tsum_t;
	typedef logic signed [TRW-1:0] tr_t;
	typedef logic signed [OW-1:0]  torque_t;

	// Rounding offsets for the three round-half-up shifts.
	localparam dq_t   RND_H   = dq_t'(1) <<< 13;
	localparam rsum_t RND_WCB = rsum_t'(1) <<< 21;
	localparam tsum_t RND_T   = tsum_t'(1) <<< 27;

	typedef enum logic [CFG_IW-1:0] {
		REG_PROP_GAINS    = 2'd0,
		REG_RATE_GAINS    = 2'd1,
		REG_TORQUE_LIMITS = 2'd2
	} cfg_reg_t;

	localparam logic [CFG_DW-1:0] TORQUE_LIMITS_RST = 48'h0001_0001_0001;

	// Gains and limit of one axis.
	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] kd;
		logic [15:0] lim;
	} axis_cfg_t;

	// Words that ride along the pipeline untouched.
	typedef struct packed {
		logic        ok;
		logic [63:0] quat;
		logic [47:0] rate;
	} tag_t;

	// Signed 16-bit subfield idx of a packed word.
	function automatic q_t sfield(input logic [63:0] word, input logic [1:0] idx);
		return q_t'(word[{idx, 4'b0000} +: 16]);
	endfunction

endpackage

// ===== rtl/core/pdat_if.sv =====
// ---------------------------------------------------------------------------
// PD attitude torque law channels
// Valid/ready channels for the input word and the result word.
// ---------------------------------------------------------------------------
interface pdat_in_if;
	logic        valid;
	logic        ready;
	logic        est_valid;
	logic [63:0] est_quat;
	logic [47:0] est_rate;
	logic        cmd_valid;
	logic [63:0] cmd_quat;
	logic [47:0] cmd_rate;

	modport source (
		output valid, est_valid, est_quat, est_rate, cmd_valid, cmd_quat, cmd_rate,
		input  ready
	);
	modport sink (
		input  valid, est_valid, est_quat, est_rate, cmd_valid, cmd_quat, cmd_rate,
		output ready
	);
endinterface

interface pdat_out_if;
	logic               valid;
	logic               ready;
	logic               out_valid;
	logic signed [16:0] torque_x;
	logic signed [16:0] torque_y;
	logic signed [16:0] torque_z;
	logic        [63:0] echo_quat;
	logic        [47:0] echo_rate;

	modport source (
		output valid, out_valid, torque_x, torque_y, torque_z, echo_quat, echo_rate,
		input  ready
	);
	modport sink (
		input  valid, out_valid, torque_x, torque_y, torque_z, echo_quat, echo_rate,
		output ready
	);
endinterface

// ===== rtl/core/pdat_axis.sv =====
// ---------------------------------------------------------------------------
// PD attitude torque law: one axis
// Resolves the commanded rate, forms the PD torque, rounds and saturates.
// ---------------------------------------------------------------------------
module pdat_axis
	import pdat_pkg::*;
(
	input  logic        clk,
	input  logic        adv,
	input  cm_t         c_row [3],
	input  logic [47:0] cmd_rate,
	input  q_t          est_rate,
	input  dq_t         dq,
	input  logic        neg,
	input  logic        ok,
	input  axis_cfg_t   cfg,
	output torque_t     torque
);

	rprod_t pw_s5 [3];
	q_t     we_s5, we_s6;
	dq_t    dq_s5, dq_s6;
	logic   neg_s5, neg_s6, neg_s7, neg_s8;
	wcb_t   wcb_s6;
	werr_t  werr_s7;
	apd_t   apd_s7, apd_s8;
	kdw_t   kdw_s8;
	tr_t    tr_s9;
	torque_t torque_s10;

	rsum_t  wsum;
	tsum_t  tsum;
	tr_t    lim_pos;
	tr_t    tclamp;

	always_comb begin
		wsum = RSW'(pw_s5[0]) + RSW'(pw_s5[1]) + RSW'(pw_s5[2]) + RND_WCB;
		// Sign s is +1 when the scalar part is not negative, giving -kp*dq.
		tsum = (neg_s8 ? TW'(apd_s8) : -TW'(apd_s8)) - (TW'(kdw_s8) <<< 12) + RND_T;
		lim_pos = tr_t'({1'b0, cfg.lim});
		if (tr_s9 > lim_pos) begin
			tclamp = lim_pos;
		end else if (tr_s9 < -lim_pos) begin
			tclamp = -lim_pos;
		end else begin
			tclamp = tr_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				pw_s5[j] <= c_row[j] * sfield(64'(cmd_rate), 2'(j));
			end
			we_s5  <= est_rate;
			dq_s5  <= dq;
			neg_s5 <= neg;

			wcb_s6 <= wcb_t'(wsum[RSW-1:22]);
			we_s6  <= we_s5;
			dq_s6  <= dq_s5;
			neg_s6 <= neg_s5;

			werr_s7 <= werr_t'({{(EW-22){we_s6[15]}}, we_s6, 6'b000000}) - EW'(wcb_s6);
			apd_s7  <= $signed({1'b0, cfg.kp}) * dq_s6;
			neg_s7  <= neg_s6;

			kdw_s8 <= $signed({1'b0, cfg.kd}) * werr_s7;
			apd_s8 <= apd_s7;
			neg_s8 <= neg_s7;

			tr_s9 <= tr_t'(tsum[TW-1:28]);

			torque_s10 <= ok ? torque_t'(tclamp[OW-1:0]) : '0;
		end
	end

	assign torque = torque_s10;

endmodule

// ===== rtl/core/pd_attitude_torque_law_core.sv =====
// ---------------------------------------------------------------------------
// PD attitude torque law core
// Quaternion PD attitude controller with per-axis torque saturation.
// ---------------------------------------------------------------------------
// Usage. Each input word on the inbound channel carries an attitude estimate
// (quaternion and body rate) and an attitude command (quaternion and rate),
// each with its own valid flag. For every input word the core returns exactly
// one result word on the outbound channel, in order: three saturated torques
// at 2^-8 Nm, and the command echoed. When either valid flag is low the
// result has out_valid low and every other field zero.
// Gains and limits sit in three registers written through cfg_we, cfg_index
// and cfg_data; write them only while no word is in flight.
// A new word is taken on every cycle while the output register is free or being
// read: ten register stages, each holding at most one multiply (16x16 quaternion
// products, 20x20 matrix terms, 40x16 rate resolution, 17x36 derivative term) or
// one wide add.
// The whole pipeline advances together. When the receiver stalls the output
// register holds its word and inbound.ready drops, so nothing is lost or
// repeated; bubbles between words are kept as they are. Reset clears the stage
// valid bits and restores the registers: gains zero, each limit one.
// ---------------------------------------------------------------------------
module pd_attitude_torque_law_core
	import pdat_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	pdat_in_if.sink           inbound,
	pdat_out_if.source        outbound
);

	// Configuration registers.
	logic [CFG_DW-1:0] prop_q;
	logic [CFG_DW-1:0] rate_q;
	logic [CFG_DW-1:0] lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q <= '0;
			rate_q <= '0;
			lim_q  <= TORQUE_LIMITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAINS:    prop_q <= cfg_data;
				REG_RATE_GAINS:    rate_q <= cfg_data;
				REG_TORQUE_LIMITS: lim_q  <= cfg_data;
				default:           ; // unused index, the write is dropped
			endcase
		end
	end

	// Pipeline control: every stage moves when the output register is free.
	logic           adv;
	logic [NST:1]   vld_s;
	tag_t           tag_s [NST:1];

	assign adv           = !vld_s[NST] || outbound.ready;
	assign inbound.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-1:1], inbound.valid};
		end
	end

	// The command words ride along; the last stage zeroes them for an
	// invalid input so the result word carries zeros.
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[1] <= '{ok: inbound.est_valid & inbound.cmd_valid,
				quat: inbound.cmd_quat, rate: inbound.cmd_rate};
			for (int k = 2; k < NST; k++) begin
				tag_s[k] <= tag_s[k-1];
			end
			tag_s[NST] <= tag_s[NST-1].ok ? tag_s[NST-1] : '0;
		end
	end

	// Stage 1: all sixteen products of command and estimate components.
	// Row is the command component (w,x,y,z), column the estimate component.
	qprod_t      pq_s1 [4][4];
	logic [47:0] erate_s1, erate_s2, erate_s3, erate_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				for (int k = 0; k < 4; k++) begin
					pq_s1[r][k] <= sfield(inbound.cmd_quat, 2'(r))
						* sfield(inbound.est_quat, 2'(k));
				end
			end
			erate_s1 <= inbound.est_rate;
		end
	end

	// Stage 2: error quaternion dq = conj(cmd) x est, and dq rounded to Q14.
	dq_t dsum [4];
	dq_t hsum [4];
	dq_t d_s2 [4];
	hq_t h_s2 [4];
	logic neg_s2;

	always_comb begin
		dsum[0] = DW'(pq_s1[0][0]) + DW'(pq_s1[1][1]) + DW'(pq_s1[2][2]) + DW'(pq_s1[3][3]);
		dsum[1] = DW'(pq_s1[0][1]) - DW'(pq_s1[1][0]) - DW'(pq_s1[2][3]) + DW'(pq_s1[3][2]);
		dsum[2] = DW'(pq_s1[0][2]) + DW'(pq_s1[1][3]) - DW'(pq_s1[2][0]) - DW'(pq_s1[3][1]);
		dsum[3] = DW'(pq_s1[0][3]) - DW'(pq_s1[1][2]) + DW'(pq_s1[2][1]) - DW'(pq_s1[3][0]);
		for (int r = 0; r < 4; r++) begin
			hsum[r] = dsum[r] + RND_H;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				d_s2[r] <= dsum[r];
				h_s2[r] <= hq_t'(hsum[r][DW-1:14]);
			end
			// A zero scalar part counts as a positive sign.
			neg_s2   <= dsum[0][DW-1];
			erate_s2 <= erate_s1;
		end
	end

	// Stage 3: squares and cross products of the rounded error quaternion.
	cm_t  sq_s3 [4];
	cm_t  m01_s3, m02_s3, m03_s3, m12_s3, m13_s3, m23_s3;
	dq_t  d_s3 [3];
	logic neg_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				sq_s3[r] <= h_s2[r] * h_s2[r];
			end
			m01_s3 <= h_s2[0] * h_s2[1];
			m02_s3 <= h_s2[0] * h_s2[2];
			m03_s3 <= h_s2[0] * h_s2[3];
			m12_s3 <= h_s2[1] * h_s2[2];
			m13_s3 <= h_s2[1] * h_s2[3];
			m23_s3 <= h_s2[2] * h_s2[3];
			for (int r = 0; r < 3; r++) begin
				d_s3[r] <= d_s2[r+1];
			end
			neg_s3   <= neg_s2;
			erate_s3 <= erate_s2;
		end
	end

	// Stage 4: the attitude matrix of dq.
	cm_t  c_s4 [3][3];
	dq_t  d_s4 [3];
	logic neg_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4[0][0] <= sq_s3[0] + sq_s3[1] - sq_s3[2] - sq_s3[3];
			c_s4[0][1] <= (m12_s3 + m03_s3) <<< 1;
			c_s4[0][2] <= (m13_s3 - m02_s3) <<< 1;
			c_s4[1][0] <= (m12_s3 - m03_s3) <<< 1;
			c_s4[1][1] <= sq_s3[0] - sq_s3[1] + sq_s3[2] - sq_s3[3];
			c_s4[1][2] <= (m23_s3 + m01_s3) <<< 1;
			c_s4[2][0] <= (m13_s3 + m02_s3) <<< 1;
			c_s4[2][1] <= (m23_s3 - m01_s3) <<< 1;
			c_s4[2][2] <= sq_s3[0] - sq_s3[1] - sq_s3[2] + sq_s3[3];
			d_s4     <= d_s3;
			neg_s4   <= neg_s3;
			erate_s4 <= erate_s3;
		end
	end

	// Stages 5 to 10: one lane per body axis.
	axis_cfg_t acfg [3];
	torque_t   tq   [3];

	for (genvar i = 0; i < 3; i++) begin : g_axis
		assign acfg[i] = '{kp: prop_q[16*i +: 16], kd: rate_q[16*i +: 16],
			lim: lim_q[16*i +: 16]};

		pdat_axis u_axis (
			.clk      (clk),
			.adv      (adv),
			.c_row    (c_s4[i]),
			.cmd_rate (tag_s[4].rate),
			.est_rate (sfield(64'(erate_s4), 2'(i))),
			.dq       (d_s4[i]),
			.neg      (neg_s4),
			.ok       (tag_s[NST-1].ok),
			.cfg      (acfg[i]),
			.torque   (tq[i])
		);
	end

	// Output register is stage 10.
	assign outbound.valid     = vld_s[NST];
	assign outbound.out_valid = tag_s[NST].ok;
	assign outbound.torque_x  = tq[0];
	assign outbound.torque_y  = tq[1];
	assign outbound.torque_z  = tq[2];
	assign outbound.echo_quat = tag_s[NST].quat;
	assign outbound.echo_rate = tag_s[NST].rate;

endmodule

// ===== rtl/core/pdat_checker.sv =====
// ---------------------------------------------------------------------------
// PD attitude torque law checker
// Port-level checks on the core, attached to it by a bind statement.
// ---------------------------------------------------------------------------
`include "pd_attitude_torque_law_core_defines.svh"

module pdat_checker
	import pdat_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        res_ok,
	input torque_t     torque_x,
	input torque_t     torque_y,
	input torque_t     torque_z,
	input logic [63:0] echo_quat,
	input logic [47:0] echo_rate
);

	localparam torque_t TQ_MIN = {1'b1, {(OW-1){1'b0}}};

	// A stalled result word holds still.
	`PDAT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable({res_ok, torque_x, torque_y, torque_z, echo_quat, echo_rate}),
		"result word changed while stalled")

	// With the output register empty the core always takes a word.
	`PDAT_ASSERT_NOW(a_ready_empty, clk, arst_n, !out_valid, in_ready,
		"inbound not ready with an empty output register")

	// A result from invalid inputs carries only zeros.
	`PDAT_ASSERT_NOW(a_invalid_zero, clk, arst_n, out_valid && !res_ok,
		torque_x == '0 && torque_y == '0 && torque_z == '0 && echo_quat == '0
		&& echo_rate == '0, "invalid result carries nonzero fields")

	// Saturation keeps every torque within the 16-bit limit magnitude.
	`PDAT_ASSERT_NOW(a_torque_range, clk, arst_n, out_valid,
		torque_x != TQ_MIN && torque_y != TQ_MIN && torque_z != TQ_MIN,
		"torque outside the limit range")

endmodule

bind pd_attitude_torque_law_core pdat_checker u_pdat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (inbound.ready),
	.out_valid (outbound.valid),
	.out_ready (outbound.ready),
	.res_ok    (outbound.out_valid),
	.torque_x  (outbound.torque_x),
	.torque_y  (outbound.torque_y),
	.torque_z  (outbound.torque_z),
	.echo_quat (outbound.echo_quat),
	.echo_rate (outbound.echo_rate)
);
